/* src/mstp_pkg.sv */
// package: sizes, command codes and bank interface types for the timer pool
package mstp_pkg;

  // pool size and counter width
  localparam int unsigned SLOTS     = 16;
  localparam int unsigned TIME_BITS = 32;

  // fixed field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned INTERVAL_W = 32;

  // slot index width and a compare width that holds SLOTS itself
  localparam int unsigned SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SLOT_CMP_W = 9;
  localparam int unsigned IVAL_EXT_W = 96;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
  typedef logic [TIME_BITS-1:0]  time_t;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 2'd0,
    CMD_START    = 2'd1,
    CMD_STOP     = 2'd2,
    CMD_STOP_ALL = 2'd3
  } cmd_e;

  // write requests into the slot bank
  typedef struct packed {
    logic      start_en;
    slot_idx_t start_idx;
    logic      start_once;
    time_t     start_period;
    logic      stop_en;
    slot_idx_t stop_idx;
    logic      stop_all;
    logic      scan_en;
    slot_idx_t scan_idx;
    time_t     scan_rem;
    logic      scan_disarm;
  } bank_wr_t;

  // state of the slot under scan
  typedef struct packed {
    logic  armed;
    logic  once;
    time_t reload;
    time_t rem;
  } bank_rd_t;

endpackage

/* src/mstp_slot_bank.sv */
// slot bank: armed bits, one-shot flags, reload periods and countdowns
module mstp_slot_bank (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mstp_pkg::bank_wr_t wr_i,
  input  mstp_pkg::slot_idx_t rd_idx_i,
  output mstp_pkg::bank_rd_t rd_o
);
  import mstp_pkg::*;

  logic [SLOTS-1:0] armed_q;
  logic [SLOTS-1:0] once_q;
  time_t            reload_q [SLOTS];
  time_t            rem_q    [SLOTS];

  // armed bits: start sets, stop and one-shot expiry clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
    end else if (wr_i.stop_all) begin
      armed_q <= '0;
    end else if (wr_i.start_en) begin
      armed_q[wr_i.start_idx] <= 1'b1;
    end else if (wr_i.stop_en) begin
      armed_q[wr_i.stop_idx] <= 1'b0;
    end else if (wr_i.scan_en && wr_i.scan_disarm) begin
      armed_q[wr_i.scan_idx] <= 1'b0;
    end
  end

  // per-slot payload, written by start and by the scan
  always_ff @(posedge clk_i) begin
    if (wr_i.start_en) begin
      once_q[wr_i.start_idx]   <= wr_i.start_once;
      reload_q[wr_i.start_idx] <= wr_i.start_period;
      rem_q[wr_i.start_idx]    <= wr_i.start_period;
    end else if (wr_i.scan_en) begin
      rem_q[wr_i.scan_idx] <= wr_i.scan_rem;
    end
  end

  // read port for the scan
  assign rd_o.armed  = armed_q[rd_idx_i];
  assign rd_o.once   = once_q[rd_idx_i];
  assign rd_o.reload = reload_q[rd_idx_i];
  assign rd_o.rem    = rem_q[rd_idx_i];

endmodule

/* src/mstp_dec_unit.sv */
// shared countdown unit: decrement, zero detect and reload select
module mstp_dec_unit (
  input  mstp_pkg::time_t rem_i,
  input  mstp_pkg::time_t reload_i,
  output mstp_pkg::time_t next_o,
  output logic            expired_o
);
  import mstp_pkg::*;

  time_t dec;

  // count down, reload on reaching zero
  assign dec       = rem_i - TIME_BITS'(1);
  assign expired_o = (dec == '0);
  assign next_o    = expired_o ? reload_i : dec;

endmodule

/* src/multi_slot_timer_pool_top.sv */
// top level: command decode, tick scan sequencer and result register
//
// A pool of SLOTS timer slots driven over a valid/stall input channel.
// Each item carries a command: tick, start slot, stop slot or stop all.
// Start, stop and stop-all take effect in the cycle the item is accepted
// and produce no result; the input is ready again on the next cycle.
// A tick starts a scan that walks the slots one per cycle, unless held by a
// stalled result, through a single shared countdown unit, then enters a
// flush state that releases the final result.
// The input channel is stalled for the whole scan and flush.
// Expired slots come out on the result channel in ascending slot order,
// one item each, with last set on the final one of the tick; a tick with
// no expiry gives no result. Results leave through an output register, so
// a new command is taken while a result still waits.
// When the receiver stalls, the scan holds on the next expiring slot until
// the register frees up.
// Reset disarms every slot and empties the result register; slot periods
// and countdowns hold no reset value and are loaded by start.
module multi_slot_timer_pool_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [mstp_pkg::CMD_W-1:0]          in_command_i,
  input  logic [mstp_pkg::SLOT_W-1:0]         in_slot_i,
  input  logic [mstp_pkg::INTERVAL_W-1:0]     in_interval_i,
  input  logic                                in_single_shot_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [mstp_pkg::SLOT_W-1:0]         out_fired_slot_o,
  output logic                                out_was_single_shot_o,
  output logic                                out_last_o
);
  import mstp_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam slot_idx_t LAST_IDX = SLOT_IDX_W'(SLOTS - 1);

  logic [1:0] state_q, state_d;
  slot_idx_t  idx_q, idx_d;

  logic              pend_v_q, pend_v_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic              pend_once_q, pend_once_d;

  logic              out_v_q, out_v_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_once_q, out_once_d;
  logic              out_last_q, out_last_d;

  logic acc;
  cmd_e cmd;
  logic [SLOT_CMP_W-1:0] slot_ext;
  logic                  slot_ok;
  slot_idx_t             slot_idx;
  logic [IVAL_EXT_W-1:0] ival_ext;
  time_t                 ival;
  time_t                 period;

  bank_wr_t wr;
  bank_rd_t rd;
  time_t    next_rem;
  logic     expired;

  logic                  fire;
  logic                  out_free;
  logic                  blocked;
  logic                  step;
  logic                  push;
  logic                  push_last;
  logic [SLOT_CMP_W-1:0] idx_ext;

  // input handshake and field decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign cmd        = cmd_e'(in_command_i);
  assign slot_ext   = SLOT_CMP_W'(in_slot_i);
  assign slot_ok    = (slot_ext < SLOT_CMP_W'(SLOTS));
  assign slot_idx   = slot_ext[SLOT_IDX_W-1:0];
  assign ival_ext   = IVAL_EXT_W'(in_interval_i);
  assign ival       = ival_ext[TIME_BITS-1:0];
  assign period     = (ival == '0) ? TIME_BITS'(1) : ival;

  // slot state storage
  mstp_slot_bank u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (idx_q),
    .rd_o     (rd)
  );

  // shared countdown unit
  mstp_dec_unit u_dec (
    .rem_i     (rd.rem),
    .reload_i  (rd.reload),
    .next_o    (next_rem),
    .expired_o (expired)
  );

  // scan step control
  assign fire     = (state_q == ST_SCAN) && rd.armed && expired;
  assign out_free = !out_v_q || !out_stall_i;
  assign blocked  = fire && pend_v_q && !out_free;
  assign step     = (state_q == ST_SCAN) && !blocked;
  assign idx_ext  = SLOT_CMP_W'(idx_q);

  // bank write requests
  always_comb begin
    wr              = '0;
    wr.start_idx    = slot_idx;
    wr.start_once   = in_single_shot_i;
    wr.start_period = period;
    wr.stop_idx     = slot_idx;
    wr.scan_idx     = idx_q;
    wr.scan_rem     = next_rem;
    wr.scan_disarm  = fire && rd.once;
    wr.scan_en      = step && rd.armed;
    if (acc) begin
      unique case (cmd)
        CMD_START:    wr.start_en = slot_ok;
        CMD_STOP:     wr.stop_en  = slot_ok;
        CMD_STOP_ALL: wr.stop_all = 1'b1;
        CMD_TICK:     wr.start_en = 1'b0;
        default:      wr.start_en = 1'b0;
      endcase
    end
  end

  // sequencer, pending expiry and result register
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_v_d    = pend_v_q;
    pend_slot_d = pend_slot_q;
    pend_once_d = pend_once_q;
    push        = 1'b0;
    push_last   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && (cmd == CMD_TICK)) begin
          state_d  = ST_SCAN;
          idx_d    = '0;
          pend_v_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (step) begin
          if (fire) begin
            push        = pend_v_q;
            pend_v_d    = 1'b1;
            pend_slot_d = idx_ext[SLOT_W-1:0];
            pend_once_d = rd.once;
          end
          if (idx_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end else begin
            idx_d = idx_q + SLOT_IDX_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          pend_v_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d  = ST_IDLE;
        pend_v_d = 1'b0;
      end
    endcase

    out_v_d    = out_v_q;
    out_slot_d = out_slot_q;
    out_once_d = out_once_q;
    out_last_d = out_last_q;
    if (push) begin
      out_v_d    = 1'b1;
      out_slot_d = pend_slot_q;
      out_once_d = pend_once_q;
      out_last_d = push_last;
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_slot_q <= pend_slot_d;
    pend_once_q <= pend_once_d;
    out_slot_q  <= out_slot_d;
    out_once_q  <= out_once_d;
    out_last_q  <= out_last_d;
  end

  // result channel
  assign out_valid_o           = out_v_q;
  assign out_fired_slot_o      = out_slot_q;
  assign out_was_single_shot_o = out_once_q;
  assign out_last_o            = out_last_q;

  // no expiry is held over between ticks
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_v_q)
    else $error("pending expiry left in idle");

  // an accepted tick always starts a scan
  a_tick_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (cmd == CMD_TICK)) |=> (state_q == ST_SCAN) && (idx_q == '0))
    else $error("tick did not start a scan at slot zero");

  // the final result of a tick is only released after the scan
  a_last_in_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_last) |-> (state_q == ST_FLUSH))
    else $error("last result released during scan");

  // a push never overwrites a result still waiting
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("result register overwritten while stalled");

  // the scan holds its slot while blocked on the output
  a_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blocked |=> (state_q == ST_SCAN) && (idx_q == $past(idx_q)))
    else $error("scan advanced while blocked");

endmodule

/* tb/multi_slot_timer_pool_top_tb.sv */
`timescale 1ns / 100ps
// testbench for the timer pool: directed rows, random commands against a predictor, then a full-pool output hold
module multi_slot_timer_pool_top_tb;
  import mstp_pkg::*;

  // one reported expiry
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              single;
    logic              last;
  } firing_t;

  // how a directed row is checked
  typedef enum logic [1:0] {
    WANT_PREDICTED,
    WANT_NONE,
    WANT_ONE
  } want_e;

  typedef struct {
    cmd_e                  cmd;
    logic [SLOT_W-1:0]     slot;
    logic [INTERVAL_W-1:0] ival;
    logic                  once;
    want_e                 want;
    logic [SLOT_W-1:0]     want_slot;
    logic                  want_single;
  } dir_row_t;

  // block ports
  logic                  clk_i                 = 1'b0;
  logic                  rst_ni                = 1'b0;
  logic                  in_valid_i            = 1'b0;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      in_command_i          = CMD_TICK;
  logic [SLOT_W-1:0]     in_slot_i             = '0;
  logic [INTERVAL_W-1:0] in_interval_i         = '0;
  logic                  in_single_shot_i      = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i           = 1'b0;
  logic [SLOT_W-1:0]     out_fired_slot_o;
  logic                  out_was_single_shot_o;
  logic                  out_last_o;

  // typed expectation riding along with the item
  want_e             in_want        = WANT_PREDICTED;
  logic [SLOT_W-1:0] in_want_slot   = '0;
  logic              in_want_single = 1'b0;

  bit steady_flow  = 1'b0;
  int hold_request = 0;
  int fail_count   = 0;

  // predicted pool state
  logic    slot_armed  [SLOTS] = '{default: 1'b0};
  logic    slot_once   [SLOTS] = '{default: 1'b0};
  time_t   slot_period [SLOTS] = '{default: '0};
  time_t   slot_left   [SLOTS] = '{default: '0};
  firing_t firings_due [$];

  // directed rows: extremes, every command, restart, junk in unused fields
  dir_row_t directed_rows [22] = '{
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_NONE,      4'd0,  1'b0},
    '{CMD_STOP_ALL, 4'd0,  32'd0,         1'b0, WANT_NONE,      4'd0,  1'b0},
    '{CMD_STOP,     4'd5,  32'd0,         1'b0, WANT_NONE,      4'd0,  1'b0},
    '{CMD_START,    4'd15, 32'd1,         1'b1, WANT_NONE,      4'd0,  1'b0},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_ONE,       4'd15, 1'b1},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_NONE,      4'd0,  1'b0},
    '{CMD_START,    4'd0,  32'd0,         1'b0, WANT_NONE,      4'd0,  1'b0},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_ONE,       4'd0,  1'b0},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_ONE,       4'd0,  1'b0},
    '{CMD_START,    4'd3,  32'hFFFF_FFFF, 1'b1, WANT_NONE,      4'd0,  1'b0},
    '{CMD_START,    4'd7,  32'd2,         1'b0, WANT_NONE,      4'd0,  1'b0},
    '{CMD_START,    4'd8,  32'd2,         1'b1, WANT_NONE,      4'd0,  1'b0},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_PREDICTED, 4'd0,  1'b0},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_PREDICTED, 4'd0,  1'b0},
    '{CMD_START,    4'd7,  32'd3,         1'b1, WANT_NONE,      4'd0,  1'b0},
    '{CMD_STOP,     4'd0,  32'hFFFF_FFFF, 1'b1, WANT_NONE,      4'd0,  1'b0},
    '{CMD_TICK,     4'd10, 32'hDEAD_BEEF, 1'b1, WANT_PREDICTED, 4'd0,  1'b0},
    '{CMD_STOP,     4'd3,  32'd0,         1'b1, WANT_NONE,      4'd0,  1'b0},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_PREDICTED, 4'd0,  1'b0},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_PREDICTED, 4'd0,  1'b0},
    '{CMD_STOP_ALL, 4'd15, 32'hFFFF_FFFF, 1'b1, WANT_NONE,      4'd0,  1'b0},
    '{CMD_TICK,     4'd0,  32'd0,         1'b0, WANT_NONE,      4'd0,  1'b0}
  };

  multi_slot_timer_pool_top dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_command_i          (in_command_i),
    .in_slot_i             (in_slot_i),
    .in_interval_i         (in_interval_i),
    .in_single_shot_i      (in_single_shot_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_fired_slot_o      (out_fired_slot_o),
    .out_was_single_shot_o (out_was_single_shot_o),
    .out_last_o            (out_last_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // apply one command to the predicted pool and queue the expiries it reports
  function automatic void advance_pool(cmd_e cmd, logic [SLOT_W-1:0] s, time_t iv, logic once);
    firing_t hits [$];
    firing_t hit;
    time_t   period;
    period = (iv == '0) ? time_t'(1) : iv;
    case (cmd)
      CMD_START: begin
        slot_armed[s]  = 1'b1;
        slot_once[s]   = once;
        slot_period[s] = period;
        slot_left[s]   = period;
      end
      CMD_STOP: slot_armed[s] = 1'b0;
      CMD_STOP_ALL: begin
        foreach (slot_armed[i]) slot_armed[i] = 1'b0;
      end
      default: begin
        // tick: count down every armed slot in ascending order
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_armed[i]) begin
            slot_left[i] = slot_left[i] - 1'b1;
            if (slot_left[i] == '0) begin
              hit.slot   = SLOT_W'(i);
              hit.single = slot_once[i];
              hit.last   = 1'b0;
              hits       = {hits, hit};
              if (slot_once[i]) slot_armed[i] = 1'b0;
              else slot_left[i] = slot_period[i];
            end
          end
        end
      end
    endcase
    if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
    firings_due = {firings_due, hits};
  endfunction

  // result check first, then prediction for the item taken at the same edge
  always @(posedge clk_i) begin
    firing_t got;
    firing_t want;
    firing_t typed;
    int      queued_prior;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{slot: out_fired_slot_o, single: out_was_single_shot_o, last: out_last_o};
        if (firings_due.size() == 0) begin
          $error("unexpected result: fired_slot %0d was_single_shot %0b last %0b",
                 got.slot, got.single, got.last);
          fail_count++;
        end else begin
          want = firings_due[0];
          firings_due.delete(0);
          if (got.slot !== want.slot) begin
            $error("fired_slot: expected %0d, actual %0d", want.slot, got.slot);
            fail_count++;
          end
          if (got.single !== want.single) begin
            $error("was_single_shot: expected %0b, actual %0b", want.single, got.single);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, got.last);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        queued_prior = firings_due.size();
        advance_pool(cmd_e'(in_command_i), in_slot_i, in_interval_i, in_single_shot_i);
        // typed rows replace what the predictor queued
        if (in_want != WANT_PREDICTED) begin
          while (firings_due.size() > queued_prior)
            firings_due.delete(firings_due.size() - 1);
          if (in_want == WANT_ONE) begin
            typed.slot   = in_want_slot;
            typed.single = in_want_single;
            typed.last   = 1'b1;
            firings_due  = {firings_due, typed};
          end
        end
      end
    end
  end

  // offer one item after a random gap and hold it until taken
  task automatic offer(cmd_e cmd, logic [SLOT_W-1:0] s, logic [INTERVAL_W-1:0] iv,
                       logic once, want_e want = WANT_PREDICTED,
                       logic [SLOT_W-1:0] w_slot = '0, logic w_single = 1'b0);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_command_i     <= cmd;
    in_slot_i        <= s;
    in_interval_i    <= iv;
    in_single_shot_i <= once;
    in_want          <= want;
    in_want_slot     <= w_slot;
    in_want_single   <= w_single;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // mostly short intervals so slots fire often, with the odd wide one
  function automatic logic [INTERVAL_W-1:0] pick_interval();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return INTERVAL_W'($urandom_range(1, 6));
    if (r < 88) return INTERVAL_W'($urandom_range(1, 40));
    if (r < 94) return INTERVAL_W'($urandom);
    if (r < 97) return '0;
    return '1;
  endfunction

  // one random command, junk in the fields it ignores
  task automatic random_command();
    int                    pick;
    logic [SLOT_W-1:0]     s;
    logic [INTERVAL_W-1:0] junk;
    pick = $urandom_range(0, 99);
    s    = SLOT_W'($urandom_range(0, SLOTS - 1));
    junk = INTERVAL_W'($urandom);
    if (pick < 40)
      offer(CMD_START, s, pick_interval(), 1'($urandom_range(0, 1)));
    else if (pick < 75)
      offer(CMD_TICK, s, junk, 1'($urandom_range(0, 1)));
    else if (pick < 96)
      offer(CMD_STOP, s, junk, 1'($urandom_range(0, 1)));
    else
      offer(CMD_STOP_ALL, s, junk, 1'($urandom_range(0, 1)));
  endtask

  // result side: random stall before each item, or one long hold on request
  initial begin
    int pause;
    @(posedge rst_ni);
    forever begin
      if (hold_request > 0) begin
        pause        = hold_request;
        hold_request = 0;
      end else begin
        pause = steady_flow ? 0 : $urandom_range(0, 3);
      end
      if (pause > 0) begin
        out_stall_i <= 1'b1;
        repeat (pause) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && hold_request == 0);
    end
  end

  // stimulus sequence
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r])
      offer(directed_rows[r].cmd, directed_rows[r].slot, directed_rows[r].ival,
            directed_rows[r].once, directed_rows[r].want, directed_rows[r].want_slot,
            directed_rows[r].want_single);

    // random commands, with a stretch of back-to-back traffic
    for (int k = 0; k < 270; k++) begin
      steady_flow = (k >= 100 && k < 160);
      random_command();
    end

    // fill every slot, then hold the output so scans back up into the input
    steady_flow = 1'b1;
    for (int s = 0; s < SLOTS; s++)
      offer(CMD_START, SLOT_W'(s), INTERVAL_W'(1), 1'(s % 2));
    hold_request = 80;
    repeat (3) offer(CMD_TICK, '0, '0, 1'b0);
    offer(CMD_STOP_ALL, '0, '0, 1'b0);
    steady_flow = 1'b0;
    in_valid_i <= 1'b0;

    // drain
    while (firings_due.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && firings_due.size() == 0)
      $display("multi_slot_timer_pool_top test passed");
    else
      $display("multi_slot_timer_pool_top test failed");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("multi_slot_timer_pool_top test failed");
    $finish;
  end

endmodule

/* filelist.f */
src/mstp_pkg.sv
src/mstp_slot_bank.sv
src/mstp_dec_unit.sv
src/multi_slot_timer_pool_top.sv
tb/multi_slot_timer_pool_top_tb.sv
